@@ hw/rtl/xts_pkg.sv @@
// ----------------------------------------------------------------------------
// xts_pkg: shared types, codes and character classes of the XML token scanner
// Scanner states, event codes, event record and per-character helpers.
// ----------------------------------------------------------------------------
package xts_pkg;

  localparam int POS_BITS   = 32;
  localparam int DEPTH_BITS = 16;
  localparam int CP_BITS    = 21;

  typedef logic [POS_BITS-1:0]   pos_t;
  typedef logic [DEPTH_BITS-1:0] depth_t;
  typedef logic [CP_BITS-1:0]    cp_t;

  localparam pos_t   POS_ONE   = pos_t'(1);
  localparam depth_t DEPTH_ONE = depth_t'(1);
  localparam depth_t DEPTH_MAX = '1;

  typedef enum logic [4:0] {
    S_READY, S_TAG_BEGIN, S_TAG_NAME, S_TAG_INSIDE, S_ATTR_NAME, S_ATTR_EQ,
    S_ATTR_QUOTE, S_ATTR_VALUE, S_TAG_END, S_CLOSE, S_CLOSE_NAME, S_CLOSE_END,
    S_QMARK, S_PI, S_PI_Q, S_EXCL, S_DT, S_DT_TEXT, S_DT_STR, S_ERROR
  } scan_state_t;

  typedef enum logic [1:0] {EL_TAG, EL_SELF, EL_DECL, EL_DT} el_kind_t;

  typedef enum logic [3:0] {
    EV_TEXT, EV_OPEN, EV_CLOSE, EV_ATTR, EV_PI, EV_DT_PART, EV_DT_END,
    EV_ERROR, EV_DONE
  } ev_kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ERROR = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    ev_kind_t   kind;
    logic [31:0] name_start;
    logic [31:0] name_end;
    logic [31:0] data_start;
    logic [31:0] data_end;
    logic        all_white;
    logic [1:0]  status;
  } event_t;

  localparam cp_t CH_TAB   = cp_t'(9);
  localparam cp_t CH_LF    = cp_t'(10);
  localparam cp_t CH_CR    = cp_t'(13);
  localparam cp_t CH_SP    = cp_t'(32);
  localparam cp_t CH_DQ    = cp_t'(34);
  localparam cp_t CH_SQ    = cp_t'(39);
  localparam cp_t CH_DASH  = cp_t'(45);
  localparam cp_t CH_DOT   = cp_t'(46);
  localparam cp_t CH_SLASH = cp_t'(47);
  localparam cp_t CH_COLON = cp_t'(58);
  localparam cp_t CH_LT    = cp_t'(60);
  localparam cp_t CH_EQ    = cp_t'(61);
  localparam cp_t CH_GT    = cp_t'(62);
  localparam cp_t CH_QM    = cp_t'(63);
  localparam cp_t CH_EXCL  = cp_t'(33);
  localparam cp_t CH_US    = cp_t'(95);

  function automatic logic is_ws(cp_t c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SP);
  endfunction

  function automatic logic is_letter(cp_t c);
    return (c >= cp_t'(65) && c <= cp_t'(90)) || (c >= cp_t'(97) && c <= cp_t'(122))
        || (c >= cp_t'(128));
  endfunction

  function automatic logic is_digit(cp_t c);
    return c >= cp_t'(48) && c <= cp_t'(57);
  endfunction

  function automatic logic is_tag_first(cp_t c);
    return is_letter(c) || (c == CH_US) || (c == CH_COLON);
  endfunction

  function automatic logic is_tag_char(cp_t c);
    return is_letter(c) || is_digit(c) || (c == CH_US) || (c == CH_COLON)
        || (c == CH_DASH) || (c == CH_DOT);
  endfunction

  function automatic logic is_attr_char(cp_t c);
    return is_letter(c) || is_digit(c) || (c == CH_US) || (c == CH_DASH) || (c == CH_DOT);
  endfunction

  function automatic cp_t fold(cp_t c);
    return (c >= cp_t'(65) && c <= cp_t'(90)) ? c + cp_t'(32) : c;
  endfunction

  // lower-case "xml"
  function automatic cp_t kw_decl(logic [2:0] i);
    cp_t r;
    case (i)
      3'd0:    r = cp_t'(120);
      3'd1:    r = cp_t'(109);
      default: r = cp_t'(108);
    endcase
    return r;
  endfunction

  // lower-case "doctype"
  function automatic cp_t kw_dt(logic [2:0] i);
    cp_t r;
    case (i)
      3'd0:    r = cp_t'(100);
      3'd1:    r = cp_t'(111);
      3'd2:    r = cp_t'(99);
      3'd3:    r = cp_t'(116);
      3'd4:    r = cp_t'(121);
      3'd5:    r = cp_t'(112);
      default: r = cp_t'(101);
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/xts_core.sv @@
// ----------------------------------------------------------------------------
// xts_core: scanner state and per-character transition
// Holds state and span marks; one step per enabled cycle, event out comb.
// ----------------------------------------------------------------------------
module xts_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  xts_pkg::cp_t        cp,
  input  logic                eoi,
  output logic                ev_valid,
  output xts_pkg::event_t     ev
);

  xts_pkg::scan_state_t state_r, state_nxt;
  xts_pkg::pos_t   position_r, position_nxt;
  xts_pkg::pos_t   text_mark_r, text_mark_nxt;
  xts_pkg::pos_t   tag_start_r, tag_start_nxt;
  xts_pkg::pos_t   tag_end_r, tag_end_nxt;
  xts_pkg::pos_t   attr_start_r, attr_start_nxt;
  xts_pkg::pos_t   attr_end_r, attr_end_nxt;
  xts_pkg::pos_t   data_start_r, data_start_nxt;
  xts_pkg::depth_t depth_r, depth_nxt;
  xts_pkg::el_kind_t ek_r, ek_nxt;
  logic            quote_r, quote_nxt;
  logic            white_r, white_nxt;
  logic [2:0]      parts_r, parts_nxt;
  logic [2:0]      kidx_r, kidx_nxt;
  logic            err_r, err_nxt;

  xts_pkg::pos_t        pos;
  logic                 p2;
  xts_pkg::scan_state_t p2_st;
  logic                 part_now;
  logic                 do_fail;

  always_comb begin
    state_nxt      = state_r;
    position_nxt   = position_r;
    text_mark_nxt  = text_mark_r;
    tag_start_nxt  = tag_start_r;
    tag_end_nxt    = tag_end_r;
    attr_start_nxt = attr_start_r;
    attr_end_nxt   = attr_end_r;
    data_start_nxt = data_start_r;
    depth_nxt      = depth_r;
    ek_nxt         = ek_r;
    quote_nxt      = quote_r;
    white_nxt      = white_r;
    parts_nxt      = parts_r;
    kidx_nxt       = kidx_r;
    err_nxt        = err_r;
    pos            = position_r;
    p2             = 1'b0;
    p2_st          = xts_pkg::S_READY;
    part_now       = 1'b0;
    do_fail        = 1'b0;
    ev_valid       = 1'b0;
    ev             = '0;

    if (eoi) begin
      ev_valid = 1'b1;
      ev.kind  = xts_pkg::EV_DONE;
      if (position_r == '0) ev.status = xts_pkg::ST_EMPTY;
      else if (err_r || depth_r != '0 || state_r != xts_pkg::S_READY)
        ev.status = xts_pkg::ST_ERROR;
      else ev.status = xts_pkg::ST_OK;
      state_nxt      = xts_pkg::S_READY;
      position_nxt   = '0;
      text_mark_nxt  = '0;
      tag_start_nxt  = '0;
      tag_end_nxt    = '0;
      attr_start_nxt = '0;
      attr_end_nxt   = '0;
      data_start_nxt = '0;
      depth_nxt      = '0;
      ek_nxt         = xts_pkg::EL_TAG;
      quote_nxt      = 1'b0;
      white_nxt      = 1'b1;
      parts_nxt      = '0;
      kidx_nxt       = '0;
      err_nxt        = 1'b0;
    end else begin
      position_nxt = position_r + xts_pkg::POS_ONE;
      if (!err_r) begin
        // first pass: current state
        unique case (state_r)
          xts_pkg::S_READY: begin
            if (cp == xts_pkg::CH_LT) begin
              if (text_mark_r != pos) begin
                ev_valid      = 1'b1;
                ev.kind       = xts_pkg::EV_TEXT;
                ev.data_start = text_mark_r;
                ev.data_end   = pos;
                ev.all_white  = white_r;
              end
              state_nxt     = xts_pkg::S_TAG_BEGIN;
              text_mark_nxt = pos;
              white_nxt     = 1'b1;
            end else if (!xts_pkg::is_ws(cp)) begin
              white_nxt = 1'b0;
            end
          end
          xts_pkg::S_TAG_BEGIN: begin
            if (xts_pkg::is_tag_first(cp)) begin
              state_nxt = xts_pkg::S_TAG_NAME; tag_start_nxt = pos;
            end else if (cp == xts_pkg::CH_SLASH) begin
              state_nxt = xts_pkg::S_CLOSE;
            end else if (cp == xts_pkg::CH_QM) begin
              state_nxt = xts_pkg::S_QMARK; kidx_nxt = '0;
              data_start_nxt = pos + xts_pkg::POS_ONE;
            end else if (cp == xts_pkg::CH_EXCL) begin
              state_nxt = xts_pkg::S_EXCL; kidx_nxt = '0;
            end else if (!xts_pkg::is_ws(cp)) begin
              do_fail = 1'b1;
            end
          end
          xts_pkg::S_TAG_NAME: begin
            if (!xts_pkg::is_tag_char(cp)) begin
              tag_end_nxt = pos;
              if (depth_r == xts_pkg::DEPTH_MAX) do_fail = 1'b1;
              else begin
                depth_nxt     = depth_r + xts_pkg::DEPTH_ONE;
                ek_nxt        = xts_pkg::EL_TAG;
                ev_valid      = 1'b1;
                ev.kind       = xts_pkg::EV_OPEN;
                ev.name_start = tag_start_r;
                ev.name_end   = pos;
                p2 = 1'b1; p2_st = xts_pkg::S_TAG_INSIDE;
              end
            end
          end
          xts_pkg::S_TAG_INSIDE: begin
            p2 = 1'b1; p2_st = xts_pkg::S_TAG_INSIDE;
          end
          xts_pkg::S_ATTR_NAME: begin
            if (!xts_pkg::is_attr_char(cp)) begin
              attr_end_nxt = pos;
              if (xts_pkg::is_ws(cp)) state_nxt = xts_pkg::S_ATTR_EQ;
              else if (cp == xts_pkg::CH_EQ) state_nxt = xts_pkg::S_ATTR_QUOTE;
              else do_fail = 1'b1;
            end
          end
          xts_pkg::S_ATTR_EQ: begin
            if (cp == xts_pkg::CH_EQ) state_nxt = xts_pkg::S_ATTR_QUOTE;
            else if (!xts_pkg::is_ws(cp)) do_fail = 1'b1;
          end
          xts_pkg::S_ATTR_QUOTE: begin
            if (cp == xts_pkg::CH_DQ || cp == xts_pkg::CH_SQ) begin
              quote_nxt      = (cp == xts_pkg::CH_SQ);
              data_start_nxt = pos + xts_pkg::POS_ONE;
              state_nxt      = xts_pkg::S_ATTR_VALUE;
            end else if (!xts_pkg::is_ws(cp)) begin
              do_fail = 1'b1;
            end
          end
          xts_pkg::S_ATTR_VALUE: begin
            if (cp == (quote_r ? xts_pkg::CH_SQ : xts_pkg::CH_DQ)) begin
              state_nxt     = xts_pkg::S_TAG_INSIDE;
              ev_valid      = 1'b1;
              ev.kind       = xts_pkg::EV_ATTR;
              ev.name_start = attr_start_r;
              ev.name_end   = attr_end_r;
              ev.data_start = data_start_r;
              ev.data_end   = pos;
            end
          end
          xts_pkg::S_TAG_END: begin
            if (cp == xts_pkg::CH_GT) begin
              state_nxt     = xts_pkg::S_READY;
              text_mark_nxt = pos + xts_pkg::POS_ONE;
              white_nxt     = 1'b1;
              if (ek_r == xts_pkg::EL_SELF) begin
                if (depth_r != '0) depth_nxt = depth_r - xts_pkg::DEPTH_ONE;
                ev_valid      = 1'b1;
                ev.kind       = xts_pkg::EV_CLOSE;
                ev.name_start = tag_start_r;
                ev.name_end   = tag_end_r;
              end
            end
          end
          xts_pkg::S_CLOSE: begin
            if (xts_pkg::is_tag_first(cp)) begin
              state_nxt = xts_pkg::S_CLOSE_NAME; tag_start_nxt = pos;
            end else do_fail = 1'b1;
          end
          xts_pkg::S_CLOSE_NAME: begin
            if (!xts_pkg::is_tag_char(cp)) begin
              tag_end_nxt = pos;
              p2 = 1'b1; p2_st = xts_pkg::S_CLOSE_END;
            end
          end
          xts_pkg::S_CLOSE_END: begin
            p2 = 1'b1; p2_st = xts_pkg::S_CLOSE_END;
          end
          xts_pkg::S_QMARK: begin
            if (kidx_r < 3'd3) begin
              if (xts_pkg::fold(cp) == xts_pkg::kw_decl(kidx_r)) kidx_nxt = kidx_r + 3'd1;
              else begin p2 = 1'b1; p2_st = xts_pkg::S_PI; end
            end else if (xts_pkg::is_ws(cp)) begin
              ek_nxt = xts_pkg::EL_DECL; state_nxt = xts_pkg::S_TAG_INSIDE;
            end else begin
              p2 = 1'b1; p2_st = xts_pkg::S_PI;
            end
          end
          xts_pkg::S_PI: begin
            p2 = 1'b1; p2_st = xts_pkg::S_PI;
          end
          xts_pkg::S_PI_Q: begin
            if (cp == xts_pkg::CH_GT) begin
              state_nxt     = xts_pkg::S_READY;
              text_mark_nxt = pos + xts_pkg::POS_ONE;
              white_nxt     = 1'b1;
              ev_valid      = 1'b1;
              ev.kind       = xts_pkg::EV_PI;
              ev.data_start = data_start_r;
              ev.data_end   = pos - xts_pkg::POS_ONE;
            end else if (cp != xts_pkg::CH_QM) begin
              state_nxt = xts_pkg::S_PI;
            end
          end
          xts_pkg::S_EXCL: begin
            if (kidx_r < 3'd7) begin
              if (xts_pkg::fold(cp) == xts_pkg::kw_dt(kidx_r)) kidx_nxt = kidx_r + 3'd1;
              else do_fail = 1'b1;
            end else if (xts_pkg::is_ws(cp)) begin
              ek_nxt = xts_pkg::EL_DT; state_nxt = xts_pkg::S_DT; parts_nxt = '0;
            end else do_fail = 1'b1;
          end
          xts_pkg::S_DT: begin
            p2 = 1'b1; p2_st = xts_pkg::S_DT;
          end
          xts_pkg::S_DT_TEXT: begin
            if (!xts_pkg::is_tag_char(cp)) begin
              ev_valid      = 1'b1;
              ev.kind       = xts_pkg::EV_DT_PART;
              ev.data_start = data_start_r;
              ev.data_end   = pos;
              part_now      = 1'b1;
              if (parts_r < 3'd7) parts_nxt = parts_r + 3'd1;
              p2 = 1'b1; p2_st = xts_pkg::S_DT;
            end
          end
          xts_pkg::S_DT_STR: begin
            if (cp == xts_pkg::CH_DQ) begin
              if (parts_r < 3'd7) parts_nxt = parts_r + 3'd1;
              state_nxt     = xts_pkg::S_DT;
              ev_valid      = 1'b1;
              ev.kind       = xts_pkg::EV_DT_PART;
              ev.data_start = data_start_r;
              ev.data_end   = pos;
            end
          end
          default: ;
        endcase

        // second pass: state entered on the same character
        if (p2) begin
          state_nxt = p2_st;
          unique case (p2_st)
            xts_pkg::S_TAG_INSIDE: begin
              if (xts_pkg::is_ws(cp)) begin
              end else if (xts_pkg::is_letter(cp) || cp == xts_pkg::CH_US) begin
                attr_start_nxt = pos; state_nxt = xts_pkg::S_ATTR_NAME;
              end else if (ek_nxt == xts_pkg::EL_TAG && cp == xts_pkg::CH_SLASH) begin
                ek_nxt = xts_pkg::EL_SELF; state_nxt = xts_pkg::S_TAG_END;
              end else if (ek_nxt == xts_pkg::EL_TAG && cp == xts_pkg::CH_GT) begin
                state_nxt     = xts_pkg::S_READY;
                text_mark_nxt = pos + xts_pkg::POS_ONE;
                white_nxt     = 1'b1;
              end else if (ek_nxt == xts_pkg::EL_DECL && cp == xts_pkg::CH_QM) begin
                state_nxt = xts_pkg::S_TAG_END;
              end else do_fail = 1'b1;
            end
            xts_pkg::S_CLOSE_END: begin
              if (cp == xts_pkg::CH_GT) begin
                if (depth_r == '0) do_fail = 1'b1;
                else begin
                  depth_nxt     = depth_r - xts_pkg::DEPTH_ONE;
                  state_nxt     = xts_pkg::S_READY;
                  text_mark_nxt = pos + xts_pkg::POS_ONE;
                  white_nxt     = 1'b1;
                  ev_valid      = 1'b1;
                  ev.kind       = xts_pkg::EV_CLOSE;
                  ev.name_start = tag_start_nxt;
                  ev.name_end   = tag_end_nxt;
                end
              end else if (!xts_pkg::is_ws(cp)) do_fail = 1'b1;
            end
            xts_pkg::S_PI: begin
              if (cp == xts_pkg::CH_QM) state_nxt = xts_pkg::S_PI_Q;
            end
            xts_pkg::S_DT: begin
              if (xts_pkg::is_ws(cp)) begin
              end else if (parts_nxt < 3'd2) begin
                if (xts_pkg::is_letter(cp) || cp == xts_pkg::CH_US) begin
                  state_nxt = xts_pkg::S_DT_TEXT; data_start_nxt = pos;
                end else do_fail = 1'b1;
              end else if (cp == xts_pkg::CH_DQ && parts_nxt < 3'd4) begin
                state_nxt = xts_pkg::S_DT_STR; data_start_nxt = pos + xts_pkg::POS_ONE;
              end else if (cp == xts_pkg::CH_GT) begin
                state_nxt     = xts_pkg::S_READY;
                text_mark_nxt = pos + xts_pkg::POS_ONE;
                white_nxt     = 1'b1;
                ev_valid      = 1'b1;
                ev.kind       = xts_pkg::EV_DT_END;
                // part just closed by '>' keeps its span
                if (!part_now) begin
                  ev.data_start = pos;
                  ev.data_end   = pos;
                end
              end else do_fail = 1'b1;
            end
            default: ;
          endcase
        end

        if (do_fail) begin
          err_nxt       = 1'b1;
          state_nxt     = xts_pkg::S_ERROR;
          ev_valid      = 1'b1;
          ev            = '0;
          ev.kind       = xts_pkg::EV_ERROR;
          ev.data_start = pos;
          ev.data_end   = pos;
          ev.status     = xts_pkg::ST_ERROR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= xts_pkg::S_READY;
      position_r   <= '0;
      text_mark_r  <= '0;
      tag_start_r  <= '0;
      tag_end_r    <= '0;
      attr_start_r <= '0;
      attr_end_r   <= '0;
      data_start_r <= '0;
      depth_r      <= '0;
      ek_r         <= xts_pkg::EL_TAG;
      quote_r      <= 1'b0;
      white_r      <= 1'b1;
      parts_r      <= '0;
      kidx_r       <= '0;
      err_r        <= 1'b0;
    end else if (step) begin
      state_r      <= state_nxt;
      position_r   <= position_nxt;
      text_mark_r  <= text_mark_nxt;
      tag_start_r  <= tag_start_nxt;
      tag_end_r    <= tag_end_nxt;
      attr_start_r <= attr_start_nxt;
      attr_end_r   <= attr_end_nxt;
      data_start_r <= data_start_nxt;
      depth_r      <= depth_nxt;
      ek_r         <= ek_nxt;
      quote_r      <= quote_nxt;
      white_r      <= white_nxt;
      parts_r      <= parts_nxt;
      kidx_r       <= kidx_nxt;
      err_r        <= err_nxt;
    end
  end

endmodule

@@ hw/rtl/xml_token_scanner_top.sv @@
// ----------------------------------------------------------------------------
// xml_token_scanner_top: streaming XML tokenizer, one character per beat
// Input register, scanner core, result register with valid/stall handshakes.
// ----------------------------------------------------------------------------
// One character (or an end-of-document marker) enters per beat and the block
// takes a beat every cycle while the result side keeps up. Each character is
// captured in an input register, runs through the scanner transition logic
// and, if it causes an event, lands in the result register after the input
// register. Events carry character offsets instead of strings: tag and
// attribute name spans, text/value/PI/doctype spans, a whitespace-only flag for
// text and a status on error and done events. A syntax error is sticky and
// silences output until the end marker, whose done event reports the final
// status and returns the scanner to its reset state for the next document.
// Stall on the result side backs up into in_stall after one buffered beat.
module xml_token_scanner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] in_code_point,
  input  logic        in_end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_event_kind,
  output logic [31:0] out_name_start,
  output logic [31:0] out_name_end,
  output logic [31:0] out_data_start,
  output logic [31:0] out_data_end,
  output logic        out_all_white,
  output logic [1:0]  out_status
);

  // input register
  logic            s1_valid_r;
  xts_pkg::cp_t    s1_cp_r;
  logic            s1_eoi_r;

  // result register
  logic            out_valid_r;
  xts_pkg::event_t out_ev_r;

  logic            out_free;
  logic            step;
  logic            ev_valid;
  xts_pkg::event_t ev;

  // result slot frees when empty or being taken this edge
  assign out_free = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  xts_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .cp       (s1_cp_r),
    .eoi      (s1_eoi_r),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_cp_r  <= in_code_point;
      s1_eoi_r <= in_end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && ev_valid) begin
      out_ev_r <= ev;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_ev_r.kind;
  assign out_name_start = out_ev_r.name_start;
  assign out_name_end   = out_ev_r.name_end;
  assign out_data_start = out_ev_r.data_start;
  assign out_data_end   = out_ev_r.data_end;
  assign out_all_white  = out_ev_r.all_white;
  assign out_status     = out_ev_r.status;

`ifndef SYNTH
  // back-pressure only while a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("in_stall without held result");

  // an end marker stepped through always yields a done event next cycle
  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (step && s1_eoi_r) |=> (out_valid_r && out_ev_r.kind == xts_pkg::EV_DONE))
    else $error("end marker lost its done event");

  // error events always report syntax error status
  a_error_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_r.kind == xts_pkg::EV_ERROR) |->
      (out_ev_r.status == xts_pkg::ST_ERROR))
    else $error("error event with wrong status");
`endif

endmodule
